// ----- hdl/tcw_pkg.sv -----
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   // Transaction field widths
   localparam int REQ_TYPE_W  = 3;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int COLUMN_W    = 7;
   localparam int ROW_FIELD_W = 5;
   localparam int POS_W       = 11;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PUT_CURSOR   = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PUT_POSITION = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_SET_CURSOR   = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR        = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ_CELL    = 3'd4;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'h0a;
   localparam logic [CHAR_W-1:0] SPACE_CODE      = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'h0f;

   typedef logic [ADDR_W-1:0]        cell_addr_type;
   typedef logic [ATTR_W+CHAR_W-1:0] cell_word_type;

endpackage

// ----- hdl/tcw_channels.sv -----
interface tcw_req_if;
   import tcw_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [REQ_TYPE_W-1:0]  req_type;
   logic [CHAR_W-1:0]      char_code;
   logic [ATTR_W-1:0]      attribute;
   logic [COLUMN_W-1:0]    column;
   logic [ROW_FIELD_W-1:0] row;

   modport source (output valid, req_type, char_code, attribute, column, row, input ready);
   modport sink   (input valid, req_type, char_code, attribute, column, row, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;

   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  cursor_position;
   logic [CHAR_W-1:0] read_char;
   logic [ATTR_W-1:0] read_attribute;
   logic              scrolled;

   modport source (output valid, cursor_position, read_char, read_attribute, scrolled,
                   input ready);
   modport sink   (input valid, cursor_position, read_char, read_attribute, scrolled,
                   output ready);
endinterface

interface tcw_csr_if;
   import tcw_pkg::*;

   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/text_console_writer_unit.sv -----
// Text console writer: a COLUMNS x ROWS store of character cells (attribute
// in the high byte, character in the low byte) and a cursor.
// req_chan carries one request per transaction: put at cursor, put at a
// position, set cursor, clear, or read a cell. rsp_chan returns exactly one
// transaction per request, carrying the cursor after the request, the cell
// read (zero for other requests) and a scroll flag. csr_chan writes the
// default attribute and is always ready; the user is to write it only while
// the block is idle, which the block itself does not enforce. A request is
// accepted in the idle state and run in the execute state on the cell memory,
// which has one read and one write port. A put or newline that runs past the
// last cell scrolls: the memory is copied up a row one cell per cycle and
// the last row is zeroed. Clear writes one cell per cycle.
// After reset the block sweeps the memory to zero and accepts no request
// meanwhile; the default attribute resets to 0x0f.
// The result sits in an output register; while the receiver stalls, the
// block finishes the request in hand and then holds before taking another.
module text_console_writer_unit (
   input  logic            clock,
   input  logic            reset,
   tcw_req_if.sink         req_chan,
   tcw_rsp_if.source       rsp_chan,
   tcw_csr_if.sink         csr_chan
);
   import tcw_pkg::*;

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_CLEAR  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   function automatic cell_addr_type cell_index(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
      cell_index = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
   endfunction

   cell_word_type cell_mem [CELLS];

   logic [2:0]            state_ff, state_in;
   cell_addr_type         sweep_ff, sweep_in;
   logic [REQ_TYPE_W-1:0] op_type_ff;
   logic [CHAR_W-1:0]     op_char_ff;
   logic [ATTR_W-1:0]     op_attr_ff;
   logic [ROW_W-1:0]      op_row_ff;
   logic [COL_W-1:0]      op_col_ff;
   logic [ROW_W-1:0]      cur_row_ff, cur_row_in;
   logic [COL_W-1:0]      cur_col_ff, cur_col_in;
   logic                  scr_ff, scr_in;
   logic [ATTR_W-1:0]     default_attr_ff;
   cell_word_type         rd_data_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic [CHAR_W-1:0]     rsp_char_ff;
   logic [ATTR_W-1:0]     rsp_attr_ff;
   logic                  rsp_scr_ff;

   logic                  req_fire;
   logic                  slot_free;
   logic                  load_rsp;
   logic [ROW_W-1:0]      clamp_row;
   logic [COL_W-1:0]      clamp_col;
   logic                  mem_we, mem_re;
   cell_addr_type         mem_waddr, mem_raddr;
   cell_word_type         mem_wdata;
   logic                  newline, wrap, will_scroll;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.cursor_position = rsp_pos_ff;
   assign rsp_chan.read_char       = rsp_char_ff;
   assign rsp_chan.read_attribute  = rsp_attr_ff;
   assign rsp_chan.scrolled        = rsp_scr_ff;

   always_comb begin
      clamp_col = (int'(req_chan.column) > COLUMNS - 1) ? COL_W'(COLUMNS - 1)
                                                        : COL_W'(req_chan.column);
      clamp_row = (int'(req_chan.row) > ROWS - 1) ? ROW_W'(ROWS - 1)
                                                  : ROW_W'(req_chan.row);
   end

   assign newline     = (op_char_ff == NEWLINE_CODE);
   assign wrap        = newline || (op_col_ff == COL_W'(COLUMNS - 1));
   assign will_scroll = wrap && (op_row_ff == ROW_W'(ROWS - 1));

   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      scr_in     = scr_ff;
      load_rsp   = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = sweep_ff;
      mem_wdata  = '0;
      mem_re     = 1'b0;
      mem_raddr  = cell_index(clamp_row, clamp_col);

      case (state_ff)
         S_INIT: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               mem_re   = (req_chan.req_type == REQ_READ_CELL);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            scr_in = 1'b0;
            case (op_type_ff)
               REQ_PUT_CURSOR, REQ_PUT_POSITION: begin
                  mem_we    = !newline;
                  mem_waddr = cell_index(op_row_ff, op_col_ff);
                  mem_wdata = {op_attr_ff, op_char_ff};
                  if (wrap) begin
                     cur_col_in = '0;
                     cur_row_in = will_scroll ? op_row_ff : op_row_ff + 1'b1;
                  end else begin
                     cur_col_in = op_col_ff + 1'b1;
                     cur_row_in = op_row_ff;
                  end
               end
               REQ_SET_CURSOR: begin
                  cur_row_in = op_row_ff;
                  cur_col_in = op_col_ff;
               end
               REQ_CLEAR: begin
                  cur_row_in = '0;
                  cur_col_in = '0;
               end
               default: begin
               end
            endcase
            if ((op_type_ff inside {REQ_PUT_CURSOR, REQ_PUT_POSITION}) && will_scroll) begin
               // prime the copy with the first cell of the second row
               scr_in    = 1'b1;
               mem_re    = 1'b1;
               mem_raddr = ADDR_W'(COLUMNS);
               sweep_in  = '0;
               state_in  = S_SCROLL;
            end else if (op_type_ff == REQ_CLEAR) begin
               sweep_in = '0;
               state_in = S_CLEAR;
            end else if (slot_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCROLL: begin
            // write the cell read last cycle one row up (zero on the last row), fetch the next
            mem_we    = 1'b1;
            mem_wdata = (sweep_ff < ADDR_W'(CELLS - COLUMNS)) ? rd_data_ff : '0;
            mem_re    = (sweep_ff < ADDR_W'(CELLS - COLUMNS - 1));
            mem_raddr = ADDR_W'(sweep_ff + ADDR_W'(COLUMNS + 1));
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = {default_attr_ff, SPACE_CODE};
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cell_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_INIT;
         sweep_ff        <= '0;
         cur_row_ff      <= '0;
         cur_col_ff      <= '0;
         scr_ff          <= 1'b0;
         default_attr_ff <= RESET_ATTRIBUTE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         scr_ff       <= scr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            default_attr_ff <= csr_chan.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_type_ff <= req_chan.req_type;
         op_char_ff <= req_chan.char_code;
         op_attr_ff <= (req_chan.attribute == '0) ? default_attr_ff : req_chan.attribute;
         if (req_chan.req_type == REQ_PUT_CURSOR) begin
            op_row_ff <= cur_row_ff;
            op_col_ff <= cur_col_ff;
         end else begin
            op_row_ff <= clamp_row;
            op_col_ff <= clamp_col;
         end
      end
      if (load_rsp) begin
         rsp_pos_ff  <= POS_W'(cell_index(cur_row_in, cur_col_in));
         rsp_char_ff <= (op_type_ff == REQ_READ_CELL) ? rd_data_ff[CHAR_W-1:0] : '0;
         rsp_attr_ff <= (op_type_ff == REQ_READ_CELL)
                        ? rd_data_ff[ATTR_W+CHAR_W-1:CHAR_W] : '0;
         rsp_scr_ff  <= (state_ff == S_DONE) && scr_ff;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result register overwritten while held");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cur_row_ff) <= ROWS - 1) && (int'(cur_col_ff) <= COLUMNS - 1))
      else $error("cursor outside the screen");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write of the same cell in one cycle");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_EXEC))
      else $error("accepted transaction not executed");

endmodule

// ----- test/tb_text_console_writer_unit.sv -----
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
   import tcw_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int RESET_CYCLES    = 6;
   localparam int MAX_GAP         = 19;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 12000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 50;
   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int REPORT_LIMIT    = 10;
   localparam int COLUMN_MAX      = (1 << COLUMN_W) - 1;
   localparam int ROW_MAX         = (1 << ROW_FIELD_W) - 1;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_MID   = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]  req_type;
      logic [CHAR_W-1:0]      char_code;
      logic [ATTR_W-1:0]      attribute;
      logic [COLUMN_W-1:0]    column;
      logic [ROW_FIELD_W-1:0] row;
   } console_request_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [CHAR_W-1:0] read_char;
      logic [ATTR_W-1:0] read_attribute;
      logic              scrolled;
   } console_result_type;

   class console_scoreboard;
      cell_word_type      cells [CELLS];
      logic [POS_W-1:0]   cursor;
      logic [ATTR_W-1:0]  default_attribute;
      console_result_type expected_q [$];
      int unsigned        mismatches, responses, scrolls, clears, reads;

      function new();
         foreach (cells[i]) cells[i] = '0;
         cursor = '0;
         default_attribute = RESET_ATTRIBUTE;
      endfunction

      function void set_default_attribute(logic [ATTR_W-1:0] value);
         default_attribute = value;
      endfunction

      // Saturate an out-of-range column or row to the last one
      function int clamp_cell(logic [COLUMN_W-1:0] col, logic [ROW_FIELD_W-1:0] r);
         int c;
         int rr;
         c = int'(col);
         rr = int'(r);
         if (c > COLUMNS - 1) c = COLUMNS - 1;
         if (rr > ROWS - 1) rr = ROWS - 1;
         return rr * COLUMNS + c;
      endfunction

      // Write or take a newline at pos, advance, and scroll past the last cell
      function bit put_cell(int pos, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr);
         if (pos >= CELLS) pos = CELLS - 1;
         if (attr == '0) attr = default_attribute;
         if (ch == NEWLINE_CODE) pos = (pos / COLUMNS) * COLUMNS + COLUMNS - 1;
         else cells[pos] = {attr, ch};
         pos++;
         if (pos < CELLS) begin
            cursor = POS_W'(pos);
            return 1'b0;
         end
         for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = '0;
         cursor = POS_W'(CELLS - COLUMNS);
         return 1'b1;
      endfunction

      function void note_request(console_request_type r);
         console_result_type e;
         int spot;
         e = '0;
         case (r.req_type)
            REQ_PUT_CURSOR:   e.scrolled = put_cell(int'(cursor), r.char_code, r.attribute);
            REQ_PUT_POSITION: e.scrolled = put_cell(clamp_cell(r.column, r.row),
                                                    r.char_code, r.attribute);
            REQ_SET_CURSOR:   cursor = POS_W'(clamp_cell(r.column, r.row));
            REQ_CLEAR: begin
               foreach (cells[i]) cells[i] = {default_attribute, SPACE_CODE};
               cursor = '0;
               clears++;
            end
            REQ_READ_CELL: begin
               spot = clamp_cell(r.column, r.row);
               {e.read_attribute, e.read_char} = cells[spot];
               reads++;
            end
            default: ;
         endcase
         e.cursor_position = cursor;
         if (e.scrolled) scrolls++;
         expected_q.push_back(e);
      endfunction

      function void check_response(console_result_type got);
         console_result_type want;
         responses++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("tb: response %0d with nothing expected: cursor %0d char %02h attr %02h",
                        responses, got.cursor_position, got.read_char, got.read_attribute);
            return;
         end
         want = expected_q.pop_front();
         if (got.cursor_position !== want.cursor_position || got.read_char !== want.read_char ||
             got.read_attribute !== want.read_attribute || got.scrolled !== want.scrolled) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("tb: response %0d expected cursor %0d char %02h attr %02h scroll %0b",
                        responses, want.cursor_position, want.read_char,
                        want.read_attribute, want.scrolled);
               $display("tb: response %0d actual   cursor %0d char %02h attr %02h scroll %0b",
                        responses, got.cursor_position, got.read_char,
                        got.read_attribute, got.scrolled);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   tcw_req_if req_chan ();
   tcw_rsp_if rsp_chan ();
   tcw_csr_if csr_chan ();

   text_console_writer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   console_scoreboard screen_model = new();
   bit                no_idle;
   bit                hold_off_request;
   int unsigned       requests_sent;
   int unsigned       attribute_writes;
   int unsigned       stalled_cycles = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic console_request_type make_request(logic [REQ_TYPE_W-1:0] kind,
                                                        logic [CHAR_W-1:0] ch,
                                                        logic [ATTR_W-1:0] attr,
                                                        int col, int r);
      console_request_type q;
      q.req_type  = kind;
      q.char_code = ch;
      q.attribute = attr;
      q.column    = COLUMN_W'(col);
      q.row       = ROW_FIELD_W'(r);
      return q;
   endfunction

   // Favour puts near the bottom row so that scrolls come often
   function automatic console_request_type random_request();
      console_request_type q;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) q.req_type = REQ_PUT_CURSOR;
      else if (pick < 63) q.req_type = REQ_PUT_POSITION;
      else if (pick < 73) q.req_type = REQ_SET_CURSOR;
      else if (pick < 92) q.req_type = REQ_READ_CELL;
      else if (pick < 94) q.req_type = REQ_CLEAR;
      else q.req_type = REQ_TYPE_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
      q.char_code = ($urandom_range(0, 6) == 0) ? NEWLINE_CODE : CHAR_W'($urandom);
      q.attribute = ($urandom_range(0, 3) == 0) ? '0 : ATTR_W'($urandom);
      if ($urandom_range(0, 4) == 0) q.column = COLUMN_W'($urandom_range(COLUMNS - 1, COLUMN_MAX));
      else q.column = COLUMN_W'($urandom_range(0, COLUMNS - 1));
      if ($urandom_range(0, 9) < 3) q.row = ROW_FIELD_W'($urandom_range(ROWS - 1, ROW_MAX));
      else q.row = ROW_FIELD_W'($urandom_range(0, ROWS - 1));
      return q;
   endfunction

   // Keep valid high across back-to-back transactions
   task automatic send_request(input console_request_type q);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= q.req_type;
      req_chan.char_code <= q.char_code;
      req_chan.attribute <= q.attribute;
      req_chan.column    <= q.column;
      req_chan.row       <= q.row;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      screen_model.note_request(q);
      requests_sent++;
   endtask

   // Drop valid and wait for every outstanding response
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (screen_model.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_default_attribute(input logic [ATTR_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      screen_model.set_default_attribute(value);
      attribute_writes++;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      console_result_type got;
      int gap;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         gap = draw_gap();
         if (hold_off_request) begin
            gap = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         got.cursor_position = rsp_chan.cursor_position;
         got.read_char       = rsp_chan.read_char;
         got.read_attribute  = rsp_chan.read_attribute;
         got.scrolled        = rsp_chan.scrolled;
         screen_model.check_response(got);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) ||
          (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("tb: no transaction for %0d cycles", stalled_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      console_request_type directed [$];
      logic [ATTR_W-1:0]   settings [PHASES];

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_PUT_CURSOR;
      req_chan.char_code = '0;
      req_chan.attribute = '0;
      req_chan.column    = '0;
      req_chan.row       = '0;
      csr_chan.valid     = 1'b0;
      csr_chan.data      = '0;

      settings[0] = '0;
      settings[1] = '1;
      settings[2] = ATTR_W'($urandom_range(1, 254));
      settings[3] = ATTR_W'($urandom_range(1, 254));
      settings[4] = RESET_ATTRIBUTE;

      // Extremes, newline, scroll from both put kinds, saturation, clear, unused codes
      directed.push_back(make_request(REQ_READ_CELL, 8'h00, 8'h00, 0, 0));
      directed.push_back(make_request(REQ_PUT_CURSOR, 8'h41, 8'h00, 0, 0));
      directed.push_back(make_request(REQ_PUT_CURSOR, 8'hff, 8'hff, 0, 0));
      directed.push_back(make_request(REQ_PUT_CURSOR, 8'h00, 8'h01, 0, 0));
      directed.push_back(make_request(REQ_PUT_CURSOR, NEWLINE_CODE, 8'h00, 0, 0));
      directed.push_back(make_request(REQ_READ_CELL, 8'h00, 8'h00, 0, 0));
      directed.push_back(make_request(REQ_READ_CELL, 8'h00, 8'h00, 1, 0));
      directed.push_back(make_request(REQ_PUT_POSITION, 8'h5a, 8'h80, COLUMNS - 1, ROWS - 1));
      directed.push_back(make_request(REQ_READ_CELL, 8'h00, 8'h00, COLUMNS - 2, ROWS - 2));
      directed.push_back(make_request(REQ_SET_CURSOR, 8'h00, 8'h00, COLUMN_MAX, ROW_MAX));
      directed.push_back(make_request(REQ_PUT_CURSOR, NEWLINE_CODE, 8'h33, 0, 0));
      directed.push_back(make_request(REQ_PUT_POSITION, 8'h55, 8'h00, COLUMN_MAX, ROW_MAX));
      directed.push_back(make_request(REQ_SET_CURSOR, 8'h00, 8'h00, COLUMNS - 1, 0));
      directed.push_back(make_request(REQ_PUT_CURSOR, 8'h2a, 8'h7f, 0, 0));
      directed.push_back(make_request(REQ_READ_CELL, 8'h00, 8'h00, COLUMN_MAX, ROW_MAX));
      directed.push_back(make_request(REQ_PUT_POSITION, NEWLINE_CODE, 8'h00, 40, 10));
      directed.push_back(make_request(REQ_CLEAR, 8'h00, 8'h00, 0, 0));
      directed.push_back(make_request(REQ_READ_CELL, 8'h00, 8'h00, COLUMNS - 1, ROWS - 1));
      directed.push_back(make_request(REQ_READ_CELL, 8'h00, 8'h00, COLUMN_MAX, ROW_MAX));
      directed.push_back(make_request(REQ_UNUSED_FIRST, 8'h41, 8'h12, 3, 4));
      directed.push_back(make_request(REQ_UNUSED_MID, 8'hff, 8'hff, COLUMN_MAX, ROW_MAX));
      directed.push_back(make_request(REQ_UNUSED_LAST, NEWLINE_CODE, 8'h00, 0, 0));
      directed.push_back(make_request(REQ_SET_CURSOR, 8'h00, 8'h00, 0, ROWS - 1));
      directed.push_back(make_request(REQ_PUT_CURSOR, NEWLINE_CODE, 8'h00, 0, 0));
      directed.push_back(make_request(REQ_READ_CELL, 8'h00, 8'h00, 0, ROWS - 1));

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[k]) send_request(directed[k]);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         write_default_attribute(settings[p]);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (k % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            // Stall the response side while requests keep coming
            if (p == 2 && k == 30) begin
               hold_off_request = 1'b1;
               no_idle = 1'b1;
            end
            send_request(random_request());
         end
         settle();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d requests sent, %0d responses checked, %0d mismatches",
               requests_sent, screen_model.responses, screen_model.mismatches);
      $display("tb: %0d scrolls, %0d clears, %0d cell reads over %0d default attribute writes",
               screen_model.scrolls, screen_model.clears, screen_model.reads, attribute_writes);
      if (screen_model.mismatches == 0 && screen_model.expected_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
